FILE: hw/rtl/skt_pkg.sv
`timescale 1ns / 1ps
// Shared constants, codes and types for the sorted key table.
package skt_pkg;

    localparam int TABLE_DEPTH   = 64;
    localparam int KEY_WIDTH     = 16;
    localparam int PAYLOAD_WIDTH = 32;
    localparam int IDX_W         = $clog2(TABLE_DEPTH);
    localparam int CNT_W         = $clog2(TABLE_DEPTH + 1);
    localparam int OP_W          = 3;
    localparam int STATUS_W      = 2;

    localparam logic [OP_W-1:0] OP_FIND   = 3'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 3'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 3'd2;
    localparam logic [OP_W-1:0] OP_NEXT   = 3'd3;
    localparam logic [OP_W-1:0] OP_PREV   = 3'd4;

    localparam logic [STATUS_W-1:0] STAT_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_NONE = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL = 2'd2;

    typedef struct packed {
        logic [KEY_WIDTH-1:0]     key;
        logic [PAYLOAD_WIDTH-1:0] payload;
    } entry_t;

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_SRD  = 7'b0000010,
        ST_SCMP = 7'b0000100,
        ST_LOOK = 7'b0001000,
        ST_SHUP = 7'b0010000,
        ST_SHDN = 7'b0100000,
        ST_DONE = 7'b1000000
    } state_t;

endpackage

FILE: hw/rtl/sorted_key_table.sv
`timescale 1ns / 1ps
// Sorted key table: ordered key/payload entries with binary search lookup.
//
// Input channel s_*: one request per transfer (opcode, key, payload, slot).
// Output channel m_*: exactly one result per request (status, found_key,
// found_payload, position, entry_count). Both channels use valid/ready.
// Entries live in one synchronous memory (one read, one write port, read
// data registered). Lookups run a binary search of at most seven probes.
// Insert moves one entry per cycle after its search; remove skips the
// search. The longest request is an insert at slot 0 of a table holding
// 63 entries. Requests are served one at a time; the next request is
// taken once the result is in the output register, even while that
// result waits for m_ready.
// Reset (aresetn low, synchronous) empties the table at once; memory
// contents are not cleared, since only slots below the entry count are read.
// A stalled receiver holds the result in the output register; a finished
// request then waits in its final state until the register is free.
module sorted_key_table (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [skt_pkg::OP_W-1:0]          s_opcode,
    input  logic [skt_pkg::KEY_WIDTH-1:0]     s_key,
    input  logic [skt_pkg::PAYLOAD_WIDTH-1:0] s_payload,
    input  logic [skt_pkg::IDX_W-1:0]         s_slot,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [skt_pkg::STATUS_W-1:0]      m_status,
    output logic [skt_pkg::KEY_WIDTH-1:0]     m_found_key,
    output logic [skt_pkg::PAYLOAD_WIDTH-1:0] m_found_payload,
    output logic [skt_pkg::IDX_W-1:0]         m_position,
    output logic [skt_pkg::CNT_W-1:0]         m_entry_count
);

    localparam int IW = skt_pkg::IDX_W;
    localparam int CW = skt_pkg::CNT_W;
    localparam logic [CW-1:0] DEPTH_C = CW'(skt_pkg::TABLE_DEPTH);

    skt_pkg::entry_t mem [skt_pkg::TABLE_DEPTH];
    skt_pkg::entry_t rd_data_reg;
    logic            mem_rd_en;
    logic [IW-1:0]   mem_rd_addr;
    logic            mem_wr_en;
    logic [IW-1:0]   mem_wr_addr;
    skt_pkg::entry_t mem_wr_data;

    skt_pkg::state_t state_reg, state_next;
    logic [skt_pkg::OP_W-1:0]          op_reg, op_next;
    logic [skt_pkg::KEY_WIDTH-1:0]     key_reg, key_next;
    logic [skt_pkg::PAYLOAD_WIDTH-1:0] pay_reg, pay_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] lo_reg, lo_next;
    logic [CW-1:0] hi_reg, hi_next;
    logic [CW-1:0] mid_reg, mid_next;
    logic [IW-1:0] tgt_reg, tgt_next;
    logic [CW-1:0] n_reg, n_next;
    logic [IW-1:0] r_reg, r_next;
    logic [IW-1:0] pa_reg, pa_next;
    logic          pend_reg, pend_next;

    logic [skt_pkg::STATUS_W-1:0]      res_status_reg, res_status_next;
    logic [skt_pkg::KEY_WIDTH-1:0]     res_key_reg, res_key_next;
    logic [skt_pkg::PAYLOAD_WIDTH-1:0] res_pay_reg, res_pay_next;
    logic [IW-1:0]                     res_pos_reg, res_pos_next;

    logic                              m_valid_reg, m_valid_next;
    logic [skt_pkg::STATUS_W-1:0]      m_status_reg, m_status_next;
    logic [skt_pkg::KEY_WIDTH-1:0]     m_key_reg, m_key_next;
    logic [skt_pkg::PAYLOAD_WIDTH-1:0] m_pay_reg, m_pay_next;
    logic [IW-1:0]                     m_pos_reg, m_pos_next;
    logic [CW-1:0]                     m_cnt_reg, m_cnt_next;

    logic [CW-1:0] mid_calc;
    logic          go_right;
    logic          key_eq;
    logic          probe_ok;
    logic [IW-1:0] probe_addr;

    assign s_ready         = (state_reg == skt_pkg::ST_IDLE);
    assign m_valid         = m_valid_reg;
    assign m_status        = m_status_reg;
    assign m_found_key     = m_key_reg;
    assign m_found_payload = m_pay_reg;
    assign m_position      = m_pos_reg;
    assign m_entry_count   = m_cnt_reg;

    assign mid_calc = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign go_right = (op_reg == skt_pkg::OP_NEXT) ? (rd_data_reg.key <= key_reg)
                                                  : (rd_data_reg.key <  key_reg);
    assign key_eq   = (rd_data_reg.key == key_reg);
    // prev looks one slot below the lower bound; the others at the bound itself
    assign probe_ok   = (op_reg == skt_pkg::OP_PREV) ? (lo_reg != '0) : (lo_reg < count_reg);
    assign probe_addr = (op_reg == skt_pkg::OP_PREV) ? IW'(lo_reg - CW'(1)) : IW'(lo_reg);

    always_ff @(posedge aclk) begin
        if (mem_wr_en) begin
            mem[mem_wr_addr] <= mem_wr_data;
        end
        if (mem_rd_en) begin
            rd_data_reg <= mem[mem_rd_addr];
        end
    end

    always_comb begin
        state_next      = state_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        pay_next        = pay_reg;
        count_next      = count_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        mid_next        = mid_reg;
        tgt_next        = tgt_reg;
        n_next          = n_reg;
        r_next          = r_reg;
        pa_next         = pa_reg;
        pend_next       = pend_reg;
        res_status_next = res_status_reg;
        res_key_next    = res_key_reg;
        res_pay_next    = res_pay_reg;
        res_pos_next    = res_pos_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_status_next   = m_status_reg;
        m_key_next      = m_key_reg;
        m_pay_next      = m_pay_reg;
        m_pos_next      = m_pos_reg;
        m_cnt_next      = m_cnt_reg;
        mem_rd_en       = 1'b0;
        mem_rd_addr     = '0;
        mem_wr_en       = 1'b0;
        mem_wr_addr     = '0;
        mem_wr_data     = '{key: key_reg, payload: pay_reg};

        case (state_reg)
            skt_pkg::ST_IDLE: begin
                if (s_valid) begin
                    op_next         = s_opcode;
                    key_next        = s_key;
                    pay_next        = s_payload;
                    lo_next         = '0;
                    hi_next         = count_reg;
                    pend_next       = 1'b0;
                    res_status_next = skt_pkg::STAT_NONE;
                    res_key_next    = '0;
                    res_pay_next    = '0;
                    res_pos_next    = '0;
                    case (s_opcode)
                        skt_pkg::OP_FIND, skt_pkg::OP_INSERT,
                        skt_pkg::OP_NEXT, skt_pkg::OP_PREV: begin
                            state_next = skt_pkg::ST_SRD;
                        end
                        skt_pkg::OP_REMOVE: begin
                            if ({1'b0, s_slot} >= count_reg) begin
                                state_next = skt_pkg::ST_DONE;
                            end else begin
                                tgt_next   = s_slot;
                                r_next     = s_slot;
                                n_next     = count_reg - {1'b0, s_slot};
                                state_next = skt_pkg::ST_SHDN;
                            end
                        end
                        default: begin
                            state_next = skt_pkg::ST_DONE;
                        end
                    endcase
                end
            end

            skt_pkg::ST_SRD: begin
                if (lo_reg < hi_reg) begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = IW'(mid_calc);
                    mid_next    = mid_calc;
                    state_next  = skt_pkg::ST_SCMP;
                end else if (probe_ok) begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = probe_addr;
                    tgt_next    = probe_addr;
                    state_next  = skt_pkg::ST_LOOK;
                end else if (op_reg == skt_pkg::OP_INSERT) begin
                    // bound is past the last entry: append or report full
                    if (count_reg >= DEPTH_C) begin
                        res_status_next = skt_pkg::STAT_FULL;
                        state_next      = skt_pkg::ST_DONE;
                    end else begin
                        tgt_next   = IW'(lo_reg);
                        n_next     = '0;
                        r_next     = IW'(count_reg - CW'(1));
                        state_next = skt_pkg::ST_SHUP;
                    end
                end else begin
                    state_next = skt_pkg::ST_DONE;
                end
            end

            skt_pkg::ST_SCMP: begin
                if (go_right) begin
                    lo_next = mid_reg + CW'(1);
                end else begin
                    hi_next = mid_reg;
                end
                state_next = skt_pkg::ST_SRD;
            end

            skt_pkg::ST_LOOK: begin
                state_next = skt_pkg::ST_DONE;
                case (op_reg)
                    skt_pkg::OP_FIND: begin
                        if (key_eq) begin
                            res_status_next = skt_pkg::STAT_OK;
                            res_key_next    = rd_data_reg.key;
                            res_pay_next    = rd_data_reg.payload;
                            res_pos_next    = tgt_reg;
                        end
                    end
                    skt_pkg::OP_INSERT: begin
                        if (key_eq) begin
                            // update the payload in place
                            mem_wr_en       = 1'b1;
                            mem_wr_addr     = tgt_reg;
                            res_status_next = skt_pkg::STAT_OK;
                            res_key_next    = key_reg;
                            res_pay_next    = pay_reg;
                            res_pos_next    = tgt_reg;
                        end else if (count_reg >= DEPTH_C) begin
                            res_status_next = skt_pkg::STAT_FULL;
                        end else begin
                            n_next     = count_reg - {1'b0, tgt_reg};
                            r_next     = IW'(count_reg - CW'(1));
                            state_next = skt_pkg::ST_SHUP;
                        end
                    end
                    default: begin
                        res_status_next = skt_pkg::STAT_OK;
                        res_key_next    = rd_data_reg.key;
                        res_pay_next    = rd_data_reg.payload;
                        res_pos_next    = tgt_reg;
                    end
                endcase
            end

            skt_pkg::ST_SHUP: begin
                // read slot r, write it one slot higher on the next cycle
                if (pend_reg) begin
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = pa_reg + IW'(1);
                    mem_wr_data = rd_data_reg;
                end
                if (n_reg != '0) begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = r_reg;
                    pa_next     = r_reg;
                    r_next      = r_reg - IW'(1);
                    n_next      = n_reg - CW'(1);
                    pend_next   = 1'b1;
                end else begin
                    pend_next = 1'b0;
                end
                if (!pend_reg && n_reg == '0) begin
                    mem_wr_en       = 1'b1;
                    mem_wr_addr     = tgt_reg;
                    count_next      = count_reg + CW'(1);
                    res_status_next = skt_pkg::STAT_OK;
                    res_key_next    = key_reg;
                    res_pay_next    = pay_reg;
                    res_pos_next    = tgt_reg;
                    state_next      = skt_pkg::ST_DONE;
                end
            end

            skt_pkg::ST_SHDN: begin
                // first read is the removed entry; the rest move down one slot
                if (pend_reg) begin
                    if (pa_reg == tgt_reg) begin
                        res_key_next = rd_data_reg.key;
                        res_pay_next = rd_data_reg.payload;
                    end else begin
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = pa_reg - IW'(1);
                        mem_wr_data = rd_data_reg;
                    end
                end
                if (n_reg != '0) begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = r_reg;
                    pa_next     = r_reg;
                    r_next      = r_reg + IW'(1);
                    n_next      = n_reg - CW'(1);
                    pend_next   = 1'b1;
                end else begin
                    pend_next = 1'b0;
                end
                if (!pend_reg && n_reg == '0) begin
                    count_next      = count_reg - CW'(1);
                    res_status_next = skt_pkg::STAT_OK;
                    res_pos_next    = tgt_reg;
                    state_next      = skt_pkg::ST_DONE;
                end
            end

            skt_pkg::ST_DONE: begin
                // hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_key_next    = res_key_reg;
                    m_pay_next    = res_pay_reg;
                    m_pos_next    = res_pos_reg;
                    m_cnt_next    = count_reg;
                    state_next    = skt_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = skt_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= skt_pkg::ST_IDLE;
            count_reg   <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg         <= op_next;
        key_reg        <= key_next;
        pay_reg        <= pay_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        mid_reg        <= mid_next;
        tgt_reg        <= tgt_next;
        n_reg          <= n_next;
        r_reg          <= r_next;
        pa_reg         <= pa_next;
        res_status_reg <= res_status_next;
        res_key_reg    <= res_key_next;
        res_pay_reg    <= res_pay_next;
        res_pos_reg    <= res_pos_next;
        m_status_reg   <= m_status_next;
        m_key_reg      <= m_key_next;
        m_pay_reg      <= m_pay_next;
        m_pos_reg      <= m_pos_next;
        m_cnt_reg      <= m_cnt_next;
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= DEPTH_C)
        else $error("entry count exceeds table depth");

    a_no_rw_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        (mem_wr_en && mem_rd_en) |-> (mem_wr_addr != mem_rd_addr))
        else $error("memory read and write hit the same entry");

    a_count_only_on_shift: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != skt_pkg::ST_SHUP && state_reg != skt_pkg::ST_SHDN)
            |=> $stable(count_reg))
        else $error("entry count changed outside a shift");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_status_reg == skt_pkg::STAT_OK ||
                         m_status_reg == skt_pkg::STAT_NONE ||
                         m_status_reg == skt_pkg::STAT_FULL))
        else $error("result carries an undefined status");

endmodule

FILE: dv/tb_sorted_key_table.sv
`timescale 1ns / 1ps
// Self-checking testbench for the sorted key table: random and directed requests.
module tb_sorted_key_table;

    localparam int POOL_SIZE      = 96;
    localparam int LONG_HOLD      = 400;
    localparam int STALL_LIMIT    = 5000;
    localparam int TAIL_CYCLES    = 120;

    typedef struct {
        logic [skt_pkg::STATUS_W-1:0]      status;
        logic [skt_pkg::KEY_WIDTH-1:0]     found_key;
        logic [skt_pkg::PAYLOAD_WIDTH-1:0] found_payload;
        logic [skt_pkg::IDX_W-1:0]         position;
        logic [skt_pkg::CNT_W-1:0]         entry_count;
    } table_result_t;

    // Shadow copy of the ordered table plus the results it predicts.
    class key_table_model;
        logic [skt_pkg::KEY_WIDTH-1:0]     keys [skt_pkg::TABLE_DEPTH];
        logic [skt_pkg::PAYLOAD_WIDTH-1:0] pays [skt_pkg::TABLE_DEPTH];
        int                                held;
        int                                errors;
        table_result_t                     pending_results [$];

        function new();
            held   = 0;
            errors = 0;
        endfunction

        function int pending_count();
            return pending_results.size();
        endfunction

        // First slot with key >= k (> k when strict), or held when none.
        function int lower_slot(logic [skt_pkg::KEY_WIDTH-1:0] k, bit strict);
            int lo, hi, mid;
            lo = 0;
            hi = held;
            while (lo < hi) begin
                mid = lo + (hi - lo) / 2;
                if (strict ? (keys[mid] <= k) : (keys[mid] < k))
                    lo = mid + 1;
                else
                    hi = mid;
            end
            return lo;
        endfunction

        function table_result_t entry_at(int s);
            table_result_t r;
            r.status        = skt_pkg::STAT_OK;
            r.found_key     = keys[s];
            r.found_payload = pays[s];
            r.position      = skt_pkg::IDX_W'(s);
            r.entry_count   = '0;
            return r;
        endfunction

        function void accept_request(logic [skt_pkg::OP_W-1:0] op,
                                     logic [skt_pkg::KEY_WIDTH-1:0] k,
                                     logic [skt_pkg::PAYLOAD_WIDTH-1:0] p,
                                     logic [skt_pkg::IDX_W-1:0] slot);
            table_result_t r;
            int s;
            r.status        = skt_pkg::STAT_NONE;
            r.found_key     = '0;
            r.found_payload = '0;
            r.position      = '0;
            r.entry_count   = '0;
            case (op)
                skt_pkg::OP_FIND: begin
                    s = lower_slot(k, 1'b0);
                    if (s < held && keys[s] == k) r = entry_at(s);
                end
                skt_pkg::OP_INSERT: begin
                    s = lower_slot(k, 1'b0);
                    if (s < held && keys[s] == k) begin
                        pays[s] = p;
                        r = entry_at(s);
                    end else if (held >= skt_pkg::TABLE_DEPTH) begin
                        r.status = skt_pkg::STAT_FULL;
                    end else begin
                        for (int i = held; i > s; i--) begin
                            keys[i] = keys[i-1];
                            pays[i] = pays[i-1];
                        end
                        keys[s] = k;
                        pays[s] = p;
                        held++;
                        r = entry_at(s);
                    end
                end
                skt_pkg::OP_REMOVE: begin
                    if (int'(slot) < held) begin
                        r = entry_at(int'(slot));
                        for (int i = int'(slot); i + 1 < held; i++) begin
                            keys[i] = keys[i+1];
                            pays[i] = pays[i+1];
                        end
                        held--;
                    end
                end
                skt_pkg::OP_NEXT: begin
                    s = lower_slot(k, 1'b1);
                    if (s < held) r = entry_at(s);
                end
                skt_pkg::OP_PREV: begin
                    s = lower_slot(k, 1'b0);
                    if (s > 0) r = entry_at(s - 1);
                end
                default: ;
            endcase
            r.entry_count = skt_pkg::CNT_W'(held);
            pending_results.push_back(r);
        endfunction

        function void compare_field(string name, longint unsigned want, longint unsigned got);
            if (want != got) begin
                $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(logic [skt_pkg::STATUS_W-1:0] status,
                                   logic [skt_pkg::KEY_WIDTH-1:0] fkey,
                                   logic [skt_pkg::PAYLOAD_WIDTH-1:0] fpay,
                                   logic [skt_pkg::IDX_W-1:0] pos,
                                   logic [skt_pkg::CNT_W-1:0] cnt);
            table_result_t want;
            if (pending_results.size() == 0) begin
                $error("result transfer with no request outstanding");
                errors++;
                return;
            end
            want = pending_results.pop_front();
            compare_field("status", want.status, status);
            compare_field("found_key", want.found_key, fkey);
            compare_field("found_payload", want.found_payload, fpay);
            compare_field("position", want.position, pos);
            compare_field("entry_count", want.entry_count, cnt);
        endfunction
    endclass

    logic                              aclk;
    logic                              aresetn   = 1'b0;
    logic                              s_valid   = 1'b0;
    logic                              s_ready;
    logic [skt_pkg::OP_W-1:0]          s_opcode  = '0;
    logic [skt_pkg::KEY_WIDTH-1:0]     s_key     = '0;
    logic [skt_pkg::PAYLOAD_WIDTH-1:0] s_payload = '0;
    logic [skt_pkg::IDX_W-1:0]         s_slot    = '0;
    logic                              m_valid;
    logic                              m_ready   = 1'b0;
    logic [skt_pkg::STATUS_W-1:0]      m_status;
    logic [skt_pkg::KEY_WIDTH-1:0]     m_found_key;
    logic [skt_pkg::PAYLOAD_WIDTH-1:0] m_found_payload;
    logic [skt_pkg::IDX_W-1:0]         m_position;
    logic [skt_pkg::CNT_W-1:0]         m_entry_count;

    key_table_model                table_model = new();
    int                            tx_idle_pct = 0;
    int                            rx_idle_pct = 0;
    bit                            hold_request = 1'b0;
    bit                            filling = 1'b1;
    logic [skt_pkg::KEY_WIDTH-1:0] key_pool [POOL_SIZE];

    sorted_key_table uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_opcode        (s_opcode),
        .s_key           (s_key),
        .s_payload       (s_payload),
        .s_slot          (s_slot),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_found_key     (m_found_key),
        .m_found_payload (m_found_payload),
        .m_position      (m_position),
        .m_entry_count   (m_entry_count)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Offer one request and hold it until the transfer; valid stays high afterward.
    task automatic send_request(logic [skt_pkg::OP_W-1:0] op,
                                logic [skt_pkg::KEY_WIDTH-1:0] k,
                                logic [skt_pkg::PAYLOAD_WIDTH-1:0] p,
                                logic [skt_pkg::IDX_W-1:0] slot);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_opcode  <= op;
        s_key     <= k;
        s_payload <= p;
        s_slot    <= slot;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        table_model.accept_request(op, k, p, slot);
    endtask

    // Drop valid and wait until every outstanding result has arrived.
    task automatic drain_results();
        s_valid <= 1'b0;
        while (table_model.pending_count() != 0) @(posedge aclk);
    endtask

    task automatic refill_pool();
        for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = skt_pkg::KEY_WIDTH'($urandom);
    endtask

    function automatic logic [skt_pkg::KEY_WIDTH-1:0] pick_key();
        if ($urandom_range(0, 99) < 65) return key_pool[$urandom_range(0, POOL_SIZE - 1)];
        return skt_pkg::KEY_WIDTH'($urandom);
    endfunction

    // Sweep the table between empty and full so full inserts and long shifts occur.
    task automatic random_request();
        int r;
        logic [skt_pkg::OP_W-1:0] op;
        logic [skt_pkg::IDX_W-1:0] slot;
        if (filling && table_model.held == skt_pkg::TABLE_DEPTH && $urandom_range(0, 7) == 0)
            filling = 1'b0;
        if (!filling && table_model.held == 0) filling = 1'b1;
        r = $urandom_range(0, 99);
        if (r < (filling ? 55 : 20))      op = skt_pkg::OP_INSERT;
        else if (r < (filling ? 65 : 60)) op = skt_pkg::OP_REMOVE;
        else if (r < 78)                  op = skt_pkg::OP_FIND;
        else if (r < 88)                  op = skt_pkg::OP_NEXT;
        else if (r < 98)                  op = skt_pkg::OP_PREV;
        else                              op = skt_pkg::OP_W'($urandom_range(5, 7));
        if (op == skt_pkg::OP_REMOVE && table_model.held > 0 && $urandom_range(0, 9) < 8)
            slot = skt_pkg::IDX_W'($urandom_range(0, table_model.held - 1));
        else
            slot = skt_pkg::IDX_W'($urandom);
        send_request(op, pick_key(), skt_pkg::PAYLOAD_WIDTH'($urandom), slot);
    endtask

    task automatic run_random(int n);
        repeat (n) random_request();
    endtask

    task automatic run_directed();
        send_request(skt_pkg::OP_FIND,   16'h0000, 32'h0, 6'd0);
        send_request(skt_pkg::OP_NEXT,   16'h0000, 32'h0, 6'd0);
        send_request(skt_pkg::OP_PREV,   16'hFFFF, 32'h0, 6'd0);
        send_request(skt_pkg::OP_REMOVE, 16'h0000, 32'h0, 6'd0);
        send_request(skt_pkg::OP_INSERT, 16'h8000, 32'hFFFF_FFFF, 6'd63);
        send_request(skt_pkg::OP_INSERT, 16'h0000, 32'h0000_0000, 6'd0);
        send_request(skt_pkg::OP_INSERT, 16'hFFFF, 32'hA5A5_A5A5, 6'd21);
        // update in place
        send_request(skt_pkg::OP_INSERT, 16'h8000, 32'h1234_5678, 6'd0);
        send_request(skt_pkg::OP_FIND,   16'h8000, 32'h0, 6'd0);
        send_request(skt_pkg::OP_FIND,   16'h7FFF, 32'h0, 6'd0);
        send_request(skt_pkg::OP_NEXT,   16'hFFFF, 32'h0, 6'd0);
        send_request(skt_pkg::OP_NEXT,   16'h0000, 32'h0, 6'd0);
        send_request(skt_pkg::OP_PREV,   16'h0000, 32'h0, 6'd0);
        send_request(skt_pkg::OP_PREV,   16'hFFFF, 32'h0, 6'd0);
        send_request(skt_pkg::OP_NEXT,   16'h7FFF, 32'h0, 6'd0);
        send_request(skt_pkg::OP_REMOVE, 16'h0000, 32'h0, 6'd63);
        send_request(skt_pkg::OP_REMOVE, 16'h0000, 32'h0, 6'd3);
        send_request(skt_pkg::OP_W'(5),  16'hFFFF, 32'hFFFF_FFFF, 6'd0);
        send_request(skt_pkg::OP_W'(6),  16'h8000, 32'h0, 6'd1);
        send_request(skt_pkg::OP_W'(7),  16'h0000, 32'h5555_AAAA, 6'd63);
        send_request(skt_pkg::OP_REMOVE, 16'h0000, 32'h0, 6'd2);
        send_request(skt_pkg::OP_REMOVE, 16'h0000, 32'h0, 6'd0);
        send_request(skt_pkg::OP_FIND,   16'h0000, 32'h0, 6'd0);
        send_request(skt_pkg::OP_INSERT, 16'h5555, 32'h5555_AAAA, 6'd42);
    endtask

    initial begin : result_sink
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (m_valid === 1'b1 && m_ready)
                table_model.check_result(m_status, m_found_key, m_found_payload,
                                         m_position, m_entry_count);
            if (hold_request) begin
                hold_left    = LONG_HOLD;
                hold_request = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        forever begin
            @(posedge aclk);
            if ((s_valid && s_ready === 1'b1) || (m_valid === 1'b1 && m_ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= STALL_LIMIT) begin
                $display("sorted_key_table verification failed");
                $finish;
            end
        end
    end

    initial begin : stimulus
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        tx_idle_pct = 9;
        rx_idle_pct = 80;
        refill_pool();
        run_directed();
        run_random(250);
        hold_request = 1'b1;
        run_random(250);
        drain_results();

        tx_idle_pct = 80;
        rx_idle_pct = 9;
        refill_pool();
        run_random(250);
        drain_results();
        run_random(250);
        drain_results();

        // no idling; a long receiver hold backs the block up into its input
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        refill_pool();
        hold_request = 1'b1;
        run_random(276);
        drain_results();
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (table_model.errors == 0 && table_model.pending_count() == 0)
            $display("sorted_key_table verification clean");
        else
            $display("sorted_key_table verification failed");
        $finish;
    end
endmodule
